// ===== hdl/pbfe_pkg.sv =====
package pbfe_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [2:0] byte_kind;
        logic [7:0] byte_value;
        logic       message_done;
        logic [2:0] message_status;
    } out_t;

    // parse phases
    localparam logic [2:0] PH_TAG    = 3'd0;
    localparam logic [2:0] PH_VARINT = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    // field kinds
    localparam logic [1:0] FK_SKIP      = 2'd0;
    localparam logic [1:0] FK_NAMESPACE = 2'd1;
    localparam logic [1:0] FK_PAYLOAD   = 2'd2;

    // byte kinds
    localparam logic [2:0] KIND_SKIP     = 3'd0;
    localparam logic [2:0] KIND_NS_START = 3'd1;
    localparam logic [2:0] KIND_NS_BYTE  = 3'd2;
    localparam logic [2:0] KIND_PL_START = 3'd3;
    localparam logic [2:0] KIND_PL_BYTE  = 3'd4;

    // message status
    localparam logic [2:0] ST_VALID   = 3'd0;
    localparam logic [2:0] ST_TRUNC   = 3'd1;
    localparam logic [2:0] ST_WIRE    = 3'd2;
    localparam logic [2:0] ST_LONG    = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam int TAG_W = 35;
    localparam int LEN_W = 21;
    localparam int SHIFT_W = 4;
    localparam logic [SHIFT_W-1:0] VARINT_LAST = 4'd9;
    localparam logic [31:0] FIELD_NAMESPACE = 32'd4;
    localparam logic [31:0] FIELD_PAYLOAD   = 32'd6;
    localparam int FIX64_BYTES = 8;
    localparam int FIX32_BYTES = 4;

endpackage

// ===== hdl/pbfe_parser.sv =====
module pbfe_parser #(
    parameter int MAX_MESSAGE    = 16384,
    parameter int NAMESPACE_KEEP = 95
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  pbfe_pkg::in_t word,
    output pbfe_pkg::out_t res
);
    import pbfe_pkg::*;

    localparam int BL_W  = $clog2(MAX_MESSAGE + 1);
    localparam int CNT_W = $clog2(NAMESPACE_KEEP + 1);

    logic [2:0]         phase_reg, phase_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               big_reg, big_next;
    logic [BL_W-1:0]    left_reg, left_next;
    logic [1:0]         fk_reg, fk_next;
    logic [CNT_W-1:0]   ns_cnt_reg, ns_cnt_next;
    logic               ns_present_reg, ns_present_next;
    logic               pl_present_reg, pl_present_next;
    logic [2:0]         err_reg, err_next;

    logic [6:0]         chunk;
    logic               more;
    logic [TAG_W-1:0]   tag_part;
    logic [LEN_W-1:0]   len_part;
    logic [BL_W-1:0]    left_dec;
    logic [2:0]         kind;
    logic [2:0]         status;

    assign chunk = word.data_byte[6:0];
    assign more  = word.data_byte[7];

    always_comb
    begin
        case (shift_reg)
            4'd0:    tag_part = TAG_W'(chunk);
            4'd1:    tag_part = TAG_W'(chunk) << 7;
            4'd2:    tag_part = TAG_W'(chunk) << 14;
            4'd3:    tag_part = TAG_W'(chunk) << 21;
            4'd4:    tag_part = TAG_W'(chunk) << 28;
            default: tag_part = '0;
        endcase
        case (shift_reg)
            4'd0:    len_part = LEN_W'(chunk);
            4'd1:    len_part = LEN_W'(chunk) << 7;
            4'd2:    len_part = LEN_W'(chunk) << 14;
            default: len_part = '0;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        tag_next        = tag_reg;
        len_next        = len_reg;
        big_next        = big_reg;
        left_next       = left_reg;
        fk_next         = fk_reg;
        ns_cnt_next     = ns_cnt_reg;
        ns_present_next = ns_present_reg;
        pl_present_next = pl_present_reg;
        err_next        = err_reg;
        kind            = KIND_SKIP;
        status          = ST_VALID;
        left_dec        = left_reg;

        case (phase_reg)
            PH_TAG:
            begin
                tag_next = tag_reg | tag_part;
                if (more)
                begin
                    shift_next = shift_reg + 1'b1;
                    if (shift_reg == VARINT_LAST)
                    begin
                        err_next   = ST_LONG;
                        phase_next = PH_ERROR;
                    end
                end
                else
                begin
                    shift_next = '0;
                    case (tag_next[2:0])
                        WT_VARINT: phase_next = PH_VARINT;
                        WT_FIX64:
                        begin
                            fk_next    = FK_SKIP;
                            left_next  = BL_W'(FIX64_BYTES);
                            phase_next = PH_BODY;
                        end
                        WT_FIX32:
                        begin
                            fk_next    = FK_SKIP;
                            left_next  = BL_W'(FIX32_BYTES);
                            phase_next = PH_BODY;
                        end
                        WT_LEN:
                        begin
                            if (tag_next[34:3] == FIELD_NAMESPACE)
                                fk_next = FK_NAMESPACE;
                            else if (tag_next[34:3] == FIELD_PAYLOAD)
                                fk_next = FK_PAYLOAD;
                            else
                                fk_next = FK_SKIP;
                            len_next   = '0;
                            big_next   = 1'b0;
                            phase_next = PH_LENGTH;
                        end
                        default:
                        begin
                            err_next   = ST_WIRE;
                            phase_next = PH_ERROR;
                        end
                    endcase
                end
            end
            PH_VARINT:
            begin
                if (more)
                begin
                    shift_next = shift_reg + 1'b1;
                    if (shift_reg == VARINT_LAST)
                    begin
                        err_next   = ST_LONG;
                        phase_next = PH_ERROR;
                    end
                end
                else
                begin
                    phase_next = PH_TAG;
                    shift_next = '0;
                    tag_next   = '0;
                end
            end
            PH_LENGTH:
            begin
                if (chunk != 7'd0)
                begin
                    // groups from bit 21 up can only make the length too large
                    if (shift_reg >= 4'd3)
                        big_next = 1'b1;
                    else
                        len_next = len_reg | len_part;
                end
                if (more)
                begin
                    shift_next = shift_reg + 1'b1;
                    if (shift_reg == VARINT_LAST)
                    begin
                        err_next   = ST_LONG;
                        phase_next = PH_ERROR;
                    end
                end
                else if (big_next || len_next > LEN_W'(MAX_MESSAGE))
                begin
                    err_next   = ST_TRUNC;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    if (fk_reg == FK_NAMESPACE)
                    begin
                        ns_present_next = (len_next != '0);
                        ns_cnt_next     = '0;
                    end
                    else if (fk_reg == FK_PAYLOAD)
                    begin
                        pl_present_next = 1'b1;
                    end
                    left_next  = BL_W'(len_next);
                    shift_next = '0;
                    if (len_next == '0)
                    begin
                        phase_next = PH_TAG;
                        tag_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (fk_reg == FK_NAMESPACE)
                begin
                    if (ns_cnt_reg < CNT_W'(NAMESPACE_KEEP))
                    begin
                        kind        = (ns_cnt_reg == '0) ? KIND_NS_START : KIND_NS_BYTE;
                        ns_cnt_next = ns_cnt_reg + 1'b1;
                    end
                end
                else if (fk_reg == FK_PAYLOAD)
                begin
                    kind = (LEN_W'(left_reg) == len_reg) ? KIND_PL_START : KIND_PL_BYTE;
                end
                if (left_reg != '0)
                    left_dec = left_reg - 1'b1;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_TAG;
                    shift_next = '0;
                    tag_next   = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (word.final_byte)
        begin
            if (phase_next == PH_ERROR)
                status = err_next;
            else if (phase_next != PH_TAG || shift_next != '0)
                status = ST_TRUNC;
            else if (!ns_present_next || !pl_present_next)
                status = ST_MISSING;
            else
                status = ST_VALID;
            // back to the idle state for the next message
            phase_next      = PH_TAG;
            shift_next      = '0;
            tag_next        = '0;
            len_next        = '0;
            big_next        = 1'b0;
            left_next       = '0;
            fk_next         = FK_SKIP;
            ns_cnt_next     = '0;
            ns_present_next = 1'b0;
            pl_present_next = 1'b0;
            err_next        = ST_VALID;
        end
    end

    assign res.byte_kind      = kind;
    assign res.byte_value     = word.data_byte;
    assign res.message_done   = word.final_byte;
    assign res.message_status = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG;
            shift_reg      <= '0;
            tag_reg        <= '0;
            len_reg        <= '0;
            big_reg        <= 1'b0;
            left_reg       <= '0;
            fk_reg         <= FK_SKIP;
            ns_cnt_reg     <= '0;
            ns_present_reg <= 1'b0;
            pl_present_reg <= 1'b0;
            err_reg        <= ST_VALID;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            tag_reg        <= tag_next;
            len_reg        <= len_next;
            big_reg        <= big_next;
            left_reg       <= left_next;
            fk_reg         <= fk_next;
            ns_cnt_reg     <= ns_cnt_next;
            ns_present_reg <= ns_present_next;
            pl_present_reg <= pl_present_next;
            err_reg        <= err_next;
        end
    end

endmodule

// ===== hdl/protobuf_field_extractor.sv =====
// Output: the result word for an accepted byte is registered in the output register.
// Throughput: one byte per cycle; the parser state update is combinational logic
// feeding the output register, and a new byte is taken whenever that register drains.
// Reset: rst_n clears the parser to the expect-tag state and empties the output register.
module protobuf_field_extractor #(
    parameter int MAX_MESSAGE    = 16384,
    parameter int NAMESPACE_KEEP = 95
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  pbfe_pkg::in_t   item,
    output logic            result_valid,
    input  logic            result_ready,
    output pbfe_pkg::out_t  result
);
    import pbfe_pkg::*;

    logic accept;
    out_t res;
    out_t res_reg;
    logic res_valid_reg, res_valid_next;

    // take a new word whenever the output slot is empty or draining
    assign item_ready = !res_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    pbfe_parser #(
        .MAX_MESSAGE   (MAX_MESSAGE),
        .NAMESPACE_KEEP(NAMESPACE_KEEP)
    ) u_parser (
        .clk  (clk),
        .rst_n(rst_n),
        .step (accept),
        .word (item),
        .res  (res)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== tb/sv/tb_protobuf_field_extractor.sv =====
module tb_protobuf_field_extractor;

    import pbfe_pkg::*;

    localparam int MSG_LIMIT   = 16384;
    localparam int NS_KEEP     = 95;
    localparam int CYCLE_LIMIT = 150000;
    localparam int DRAIN_WAIT  = 4;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    in_t  item;
    logic result_valid;
    logic result_ready;
    out_t result;

    protobuf_field_extractor #(
        .MAX_MESSAGE    (MSG_LIMIT),
        .NAMESPACE_KEEP (NS_KEEP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // parser state mirrored for prediction
    logic [2:0]   parse_ph;
    logic [3:0]   group_count;
    logic [34:0]  tag_bits;
    logic [20:0]  len_bits;
    logic         len_overflow;
    logic [14:0]  body_left;
    logic [1:0]   field_sel;
    logic [6:0]   ns_kept;
    logic         ns_seen;
    logic         pl_seen;
    logic [2:0]   first_error;

    out_t         expected_words[$];
    logic [7:0]   msg_bytes[$];
    int unsigned  items_sent;
    int unsigned  words_seen;
    int unsigned  mismatches;
    int unsigned  cycle_count;
    int unsigned  hold_cycles;
    logic         tx_idle;
    logic         rx_idle;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL protobuf_field_extractor");
            $finish;
        end
    end

    function automatic void begin_tag();
        parse_ph    = PH_TAG;
        group_count = '0;
        tag_bits    = '0;
    endfunction

    function automatic void reset_parser();
        begin_tag();
        len_bits     = '0;
        len_overflow = 1'b0;
        body_left    = '0;
        field_sel    = FK_SKIP;
        ns_kept      = '0;
        ns_seen      = 1'b0;
        pl_seen      = 1'b0;
        first_error  = ST_VALID;
    endfunction

    function automatic void abort_message(input logic [2:0] code);
        first_error = code;
        parse_ph    = PH_ERROR;
    endfunction

    function automatic void next_group();
        group_count++;
        if (group_count > VARINT_LAST)
            abort_message(ST_LONG);
    endfunction

    // expected word for one accepted byte; advances the mirrored parser
    function automatic out_t walk_byte(input in_t w);
        out_t        r;
        logic [6:0]  chunk;
        logic        more;
        int unsigned sh;
        logic [2:0]  wt;
        logic [31:0] fnum;
        chunk            = w.data_byte[6:0];
        more             = w.data_byte[7];
        sh               = 7 * int'(group_count);
        r.byte_kind      = KIND_SKIP;
        r.byte_value     = w.data_byte;
        r.message_done   = 1'b0;
        r.message_status = ST_VALID;
        case (parse_ph)
            PH_TAG:
            begin
                if (sh < TAG_W)
                    tag_bits = tag_bits | (35'(chunk) << sh);
                if (more)
                    next_group();
                else
                begin
                    wt          = tag_bits[2:0];
                    fnum        = tag_bits[34:3];
                    group_count = '0;
                    if (wt == WT_VARINT)
                        parse_ph = PH_VARINT;
                    else if (wt == WT_FIX64 || wt == WT_FIX32)
                    begin
                        field_sel = FK_SKIP;
                        body_left = (wt == WT_FIX64) ? 15'(FIX64_BYTES) : 15'(FIX32_BYTES);
                        parse_ph  = PH_BODY;
                    end
                    else if (wt == WT_LEN)
                    begin
                        field_sel    = (fnum == FIELD_NAMESPACE) ? FK_NAMESPACE
                                     : (fnum == FIELD_PAYLOAD) ? FK_PAYLOAD : FK_SKIP;
                        len_bits     = '0;
                        len_overflow = 1'b0;
                        parse_ph     = PH_LENGTH;
                    end
                    else
                        abort_message(ST_WIRE);
                end
            end
            PH_VARINT:
            begin
                if (more)
                    next_group();
                else
                    begin_tag();
            end
            PH_LENGTH:
            begin
                // nonzero groups past bit 20 make the length hopeless
                if (chunk != 0)
                begin
                    if (sh >= LEN_W)
                        len_overflow = 1'b1;
                    else
                        len_bits = len_bits | (21'(chunk) << sh);
                end
                if (more)
                    next_group();
                else if (len_overflow || len_bits > MSG_LIMIT)
                    abort_message(ST_TRUNC);
                else
                begin
                    if (field_sel == FK_NAMESPACE)
                    begin
                        ns_seen = (len_bits != 0);
                        ns_kept = '0;
                    end
                    else if (field_sel == FK_PAYLOAD)
                        pl_seen = 1'b1;
                    body_left = len_bits[14:0];
                    if (body_left == 0)
                        begin_tag();
                    else
                    begin
                        group_count = '0;
                        parse_ph    = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (field_sel == FK_NAMESPACE)
                begin
                    if (ns_kept < NS_KEEP)
                    begin
                        r.byte_kind = (ns_kept == 0) ? KIND_NS_START : KIND_NS_BYTE;
                        ns_kept++;
                    end
                end
                else if (field_sel == FK_PAYLOAD)
                    r.byte_kind = (21'(body_left) == len_bits) ? KIND_PL_START : KIND_PL_BYTE;
                if (body_left > 0)
                    body_left--;
                if (body_left == 0)
                    begin_tag();
            end
            default:
            begin
            end
        endcase
        if (w.final_byte)
        begin
            r.message_done = 1'b1;
            if (parse_ph == PH_ERROR)
                r.message_status = first_error;
            else if (parse_ph != PH_TAG || group_count != 0)
                r.message_status = ST_TRUNC;
            else if (!ns_seen || !pl_seen)
                r.message_status = ST_MISSING;
            else
                r.message_status = ST_VALID;
            reset_parser();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at word %0d: %s got %0d expected %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_word
        out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with nothing pending, byte_value", result.byte_value, 0);
            else
            begin
                want = expected_words.pop_front();
                if (result.byte_kind !== want.byte_kind)
                    report_mismatch("byte_kind", result.byte_kind, want.byte_kind);
                if (result.byte_value !== want.byte_value)
                    report_mismatch("byte_value", result.byte_value, want.byte_value);
                if (result.message_done !== want.message_done)
                    report_mismatch("message_done", result.message_done, want.message_done);
                if (result.message_status !== want.message_status)
                    report_mismatch("message_status", result.message_status,
                                    want.message_status);
            end
            words_seen++;
        end
    end

    // result side: random stall per word while rx_idle is set, plus a long hold when one is requested
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 11) : 0;
            stall += hold_cycles;
            hold_cycles = 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready));
            @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        in_t         w;
        gap          = tx_idle ? $urandom_range(0, 11) : 0;
        w.data_byte  = b;
        w.final_byte = fin;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        expected_words.push_back(walk_byte(w));
        items_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    task automatic wait_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // message building
    function automatic void push_varint(input longint unsigned v, input int unsigned pad);
        logic [7:0] b;
        do
        begin
            b    = {1'b0, v[6:0]};
            v    = v >> 7;
            b[7] = (v != 0) || (pad > 0);
            msg_bytes.push_back(b);
        end
        while (v != 0);
        // redundant zero groups, still a legal encoding
        for (int i = 0; i < pad; i++)
            msg_bytes.push_back((i == pad - 1) ? 8'h00 : 8'h80);
    endfunction

    function automatic void push_random(input int unsigned n);
        repeat (n) msg_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push_tag(input int unsigned f, input logic [2:0] wt);
        longint unsigned t;
        int unsigned     r;
        t = {29'd0, f, wt};
        r = $urandom_range(0, 9);
        if (r == 0)
            t |= {$urandom, $urandom} & 64'hFFFF_FFF8_0000_0000;
        push_varint(t, (r == 1 && t < 64'h1_0000) ? $urandom_range(1, 4) : 0);
    endfunction

    function automatic void push_length(input int unsigned n);
        push_varint(n, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 0);
    endfunction

    function automatic int unsigned small_field();
        return $urandom_range(0, 15);
    endfunction

    function automatic int unsigned other_field();
        int unsigned f;
        f = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
        if (f == FIELD_NAMESPACE || f == FIELD_PAYLOAD)
            f++;
        return f;
    endfunction

    function automatic void add_field();
        int unsigned     pick;
        int unsigned     n;
        longint unsigned v;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            push_tag(small_field(), WT_VARINT);
            n = $urandom_range(1, 10);
            v = {$urandom, $urandom};
            if (n < 10)
                v &= (64'd1 << (7 * n)) - 1;
            push_varint(v, 0);
        end
        else if (pick < 30)
        begin
            push_tag(small_field(), WT_FIX64);
            push_random(FIX64_BYTES);
        end
        else if (pick < 38)
        begin
            push_tag(small_field(), WT_FIX32);
            push_random(FIX32_BYTES);
        end
        else if (pick < 50)
        begin
            push_tag(other_field(), WT_LEN);
            n = $urandom_range(0, 6);
            push_length(n);
            push_random(n);
        end
        else if (pick < 75)
        begin
            push_tag(FIELD_NAMESPACE, WT_LEN);
            n = ($urandom_range(0, 99) < 5) ? $urandom_range(90, 110) : $urandom_range(0, 8);
            push_length(n);
            push_random(n);
        end
        else
        begin
            push_tag(FIELD_PAYLOAD, WT_LEN);
            n = $urandom_range(0, 12);
            push_length(n);
            push_random(n);
        end
    endfunction

    function automatic void break_message();
        logic [2:0]      wt;
        int unsigned     keep;
        longint unsigned v;
        case ($urandom_range(0, 5))
            0:
            begin
                // cut the message short
                keep = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > keep)
                    void'(msg_bytes.pop_back());
            end
            1:
            begin
                do
                    wt = 3'($urandom);
                while (wt == WT_VARINT || wt == WT_FIX64 || wt == WT_LEN || wt == WT_FIX32);
                push_tag(small_field(), wt);
                add_field();
            end
            2:
            begin
                if ($urandom_range(0, 1))
                    push_tag(small_field(), WT_VARINT);
                repeat ($urandom_range(10, 12))
                    msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                push_random($urandom_range(0, 2));
            end
            3:
            begin
                push_tag(small_field(), WT_LEN);
                v = $urandom_range(0, 1) ? longint'($urandom_range(MSG_LIMIT + 1, 32'h1F_FFFF))
                                         : ({$urandom, $urandom} | (64'd1 << LEN_W));
                push_varint(v, 0);
                push_random($urandom_range(0, 3));
            end
            4:
            begin
                // longest legal length, body never completes
                push_tag($urandom_range(0, 1) ? FIELD_PAYLOAD : small_field(), WT_LEN);
                push_varint(MSG_LIMIT, 0);
                push_random($urandom_range(1, 6));
            end
            default:
                push_random($urandom_range(1, 8));
        endcase
    endfunction

    function automatic void build_message();
        repeat ($urandom_range(1, 6)) add_field();
        if ($urandom_range(0, 99) < 20)
            break_message();
        if (msg_bytes.size() == 0)
            push_random(1);
    endfunction

    task automatic run_messages(input int unsigned n_bytes, input logic vary_idle);
        int unsigned stop_at;
        stop_at = items_sent + n_bytes;
        while (items_sent < stop_at)
        begin
            if (vary_idle)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            build_message();
            send_message();
        end
    endtask

    // tests
    task automatic test_directed_cases();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // namespace of one 0xFF byte, empty payload: valid
        msg_bytes = '{8'h22, 8'h01, 8'hFF, 8'h32, 8'h00};
        send_message();
        // bad wire type, then a byte that must be ignored
        msg_bytes = '{8'h0F, 8'h32};
        send_message();
        // tag varint with ten continuation groups
        repeat (9) msg_bytes.push_back(8'h80);
        msg_bytes.push_back(8'hFF);
        send_message();
        // ends right after a tag
        msg_bytes = '{8'h22};
        send_message();
        // namespace length one past the limit
        msg_bytes = '{8'h22, 8'h81, 8'h80, 8'h01};
        send_message();
        // empty namespace only: missing
        msg_bytes = '{8'h22, 8'h00};
        send_message();
    endtask

    task automatic test_random_traffic();
        run_messages(450, 1'b1);
    endtask

    task automatic test_back_to_back();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_messages(120, 1'b0);
    endtask

    task automatic test_output_stall();
        tx_idle     = 1'b0;
        rx_idle     = 1'b1;
        hold_cycles = 300;
        run_messages(60, 1'b0);
    endtask

    task automatic test_pause_between_messages();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (8)
        begin
            build_message();
            send_message();
            wait_drain();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_cycles  = 0;
        items_sent   = 0;
        words_seen   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        reset_parser();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        wait_drain();
        test_random_traffic();
        wait_drain();
        test_back_to_back();
        wait_drain();
        test_output_stall();
        wait_drain();
        test_pause_between_messages();
        wait_drain();

        if (mismatches == 0)
            $display("PASS protobuf_field_extractor");
        else
            $display("FAIL protobuf_field_extractor");
        $finish;
    end

endmodule
